/* hdl/assert_macros.svh */
// Assertion macros shared by the odometry RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* hdl/two_pkg.sv */
// Package for tracking-wheel odometry: widths, fixed-point constants, types.
// No dependencies.
`timescale 1ns / 1ps
package two_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 18;

   localparam int ANG_W  = FRAC_BITS + 5;
   localparam int COR_W  = FRAC_BITS + 8;
   localparam int WIDE_W = 64;
   localparam int PROD_W = WIDE_W + COR_W;
   localparam int DIV_W  = FRAC_BITS + COR_W;
   localparam int REM_W  = FRAC_BITS + 6;
   localparam int STEP_W = $clog2(DIV_W);
   localparam int SLOT_W = 3;
   localparam int CNT_W  = 32;
   localparam int YAW_W  = 16;
   localparam int IPC_W  = 16;
   localparam int OFF_W  = 24;
   localparam int POS_W  = 48;
   localparam int HEAD_W = 19;
   localparam int IDX_W  = 2;

   localparam logic [1:0] REG_INCH_PER_COUNT = 2'd0;
   localparam logic [1:0] REG_RIGHT_OFFSET   = 2'd1;
   localparam logic [1:0] REG_BACK_OFFSET    = 2'd2;
   localparam logic [IPC_W-1:0] IPC_RESET    = 16'd1573;

   localparam logic [SLOT_W-1:0] SLOT_R_SINC  = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_R_OFF   = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B_SINC  = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_B_OFF   = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_X_R     = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_X_B     = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_Y_R     = 3'd6;
   localparam logic [SLOT_W-1:0] SLOT_Y_B     = 3'd7;

   function automatic logic [63:0] from_q32(input logic [63:0] v);
      return (v + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   endfunction

   localparam logic [63:0] PI_Q32      = 64'd13493037705;
   localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;
   localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
   localparam logic [63:0] GAIN_Q32    = 64'd2608131496;
   localparam logic [35:0] YAW_K       = 36'd374807;

   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [COR_W-1:0]  cor_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam ang_type PI_A     = ANG_W'(from_q32(PI_Q32));
   localparam ang_type TWO_PI_A = ANG_W'(from_q32(TWO_PI_Q32));
   localparam cor_type PI_C     = COR_W'(from_q32(PI_Q32));
   localparam cor_type TWO_PI_C = COR_W'(from_q32(TWO_PI_Q32));
   localparam cor_type HALF_PI_C = COR_W'(from_q32(HALF_PI_Q32));
   localparam cor_type GAIN_C   = COR_W'(from_q32(GAIN_Q32));

   localparam logic [63:0] ATAN_Q32 [0:24] = '{
      64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
      64'd268086748, 64'd134174063, 64'd67103403, 64'd33553749,
      64'd16777131, 64'd8388597, 64'd4194303, 64'd2097152, 64'd1048576,
      64'd524288, 64'd262144, 64'd131072, 64'd65536, 64'd32768, 64'd16384,
      64'd8192, 64'd4096, 64'd2048, 64'd1024, 64'd512, 64'd256};

   function automatic cor_type atan_q(input logic [4:0] i);
      logic [63:0] v;
      v = (i > 5'd24) ? 64'd0 : ATAN_Q32[i];
      return COR_W'(from_q32(v));
   endfunction

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_YAW, OP_ANGLE, OP_DIFF, OP_CD_INIT, OP_CA_INIT,
      OP_COR_ITER, OP_CD_DONE, OP_CA_DONE, OP_DIV_INIT, OP_DIV_ITER,
      OP_DIV_DONE, OP_MUL_INIT, OP_MUL_ITER, OP_MUL_DONE, OP_ACCUM
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_YAW, S_ANGLE, S_DIFF, S_BRANCH, S_CD_INIT, S_CD_ITER,
      S_CD_DONE, S_DIV_INIT, S_DIV_ITER, S_DIV_DONE, S_MUL_INIT, S_MUL_ITER,
      S_MUL_DONE, S_CA_INIT, S_CA_ITER, S_CA_DONE, S_ACCUM
   } state_type;

   typedef struct packed {
      op_type                op;
      logic [STEP_W-1:0]     step;
      logic [SLOT_W-1:0]     slot;
   } cmd_type;

   typedef struct packed {
      logic d_zero;
      logic out_free;
   } stat_type;

endpackage

/* hdl/two_ctrl.sv */
// Sequencer for the odometry datapath: state machine, step and slot counters.
// Depends on two_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_ctrl import two_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic cor_last, div_last, mul_last;

   assign cor_last = (step_ff == STEP_W'(CORDIC_STEPS - 1));
   assign div_last = (step_ff == STEP_W'(DIV_W - 1));
   assign mul_last = (step_ff == STEP_W'(COR_W - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_YAW;
         S_YAW:      state_in = S_ANGLE;
         S_ANGLE:    state_in = S_DIFF;
         S_DIFF:     state_in = S_BRANCH;
         S_BRANCH:   state_in = stat.d_zero ? S_CA_INIT : S_CD_INIT;
         S_CD_INIT:  state_in = S_CD_ITER;
         S_CD_ITER:  if (cor_last) state_in = S_CD_DONE;
         S_CD_DONE:  state_in = S_DIV_INIT;
         S_DIV_INIT: state_in = S_DIV_ITER;
         S_DIV_ITER: if (div_last) state_in = S_DIV_DONE;
         S_DIV_DONE: state_in = S_MUL_INIT;
         S_MUL_INIT: state_in = S_MUL_ITER;
         S_MUL_ITER: if (mul_last) state_in = S_MUL_DONE;
         S_MUL_DONE: begin
            if (slot_ff == SLOT_B_OFF) state_in = S_CA_INIT;
            else if (slot_ff == SLOT_Y_B) state_in = S_ACCUM;
            else state_in = S_MUL_INIT;
         end
         S_CA_INIT:  state_in = S_CA_ITER;
         S_CA_ITER:  if (cor_last) state_in = S_CA_DONE;
         S_CA_DONE:  state_in = S_MUL_INIT;
         S_ACCUM:    if (stat.out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      step_in = '0;
      slot_in = slot_ff;
      if ((state_ff == S_CD_ITER || state_ff == S_CA_ITER) && !cor_last)
         step_in = step_ff + 1'b1;
      if (state_ff == S_DIV_ITER && !div_last) step_in = step_ff + 1'b1;
      if (state_ff == S_MUL_ITER && !mul_last) step_in = step_ff + 1'b1;
      if (state_ff == S_MUL_DONE) slot_in = slot_ff + 1'b1;
      if (state_ff == S_CA_DONE) slot_in = SLOT_X_R;
   end

   always_comb begin
      cmd.step = step_ff;
      cmd.slot = slot_ff;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE:     cmd.op = req_valid ? OP_LOAD : OP_NONE;
         S_YAW:      cmd.op = OP_YAW;
         S_ANGLE:    cmd.op = OP_ANGLE;
         S_DIFF:     cmd.op = OP_DIFF;
         S_CD_INIT:  cmd.op = OP_CD_INIT;
         S_CA_INIT:  cmd.op = OP_CA_INIT;
         S_CD_ITER,
         S_CA_ITER:  cmd.op = OP_COR_ITER;
         S_CD_DONE:  cmd.op = OP_CD_DONE;
         S_CA_DONE:  cmd.op = OP_CA_DONE;
         S_DIV_INIT: cmd.op = OP_DIV_INIT;
         S_DIV_ITER: cmd.op = OP_DIV_ITER;
         S_DIV_DONE: cmd.op = OP_DIV_DONE;
         S_MUL_INIT: cmd.op = OP_MUL_INIT;
         S_MUL_ITER: cmd.op = OP_MUL_ITER;
         S_MUL_DONE: cmd.op = OP_MUL_DONE;
         S_ACCUM:    cmd.op = stat.out_free ? OP_ACCUM : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         slot_ff  <= slot_in;
      end
   end

   `ASSERT_IMPLY(a_idle_slot, clock, reset, state_ff == S_IDLE, slot_ff == SLOT_R_SINC)
   `ASSERT_IMPLY(a_mul_step, clock, reset, state_ff == S_MUL_ITER, step_ff < STEP_W'(COR_W))
   `ASSERT_IMPLY(a_cor_step, clock, reset, state_ff == S_CD_ITER || state_ff == S_CA_ITER,
                 step_ff < STEP_W'(CORDIC_STEPS))

endmodule

/* hdl/two_dp.sv */
// Odometry datapath: heading, deltas, CORDIC, divider, shift-add multiplier,
// accumulators, config registers and result register. Depends on two_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_dp import two_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic signed [CNT_W-1:0]  req_right_count,
   input  logic signed [CNT_W-1:0]  req_back_count,
   input  logic signed [YAW_W-1:0]  req_first_yaw,
   input  logic signed [YAW_W-1:0]  req_second_yaw,
   input  logic                     csr_valid,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [OFF_W-1:0]         csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [POS_W-1:0]  rsp_pos_x,
   output logic signed [POS_W-1:0]  rsp_pos_y,
   output logic [HEAD_W-1:0]        rsp_heading
);

   logic [CNT_W-1:0] rc_ff, rc_in, bc_ff, bc_in, prc_ff, prc_in, pbc_ff, pbc_in;
   logic signed [YAW_W-1:0] y1_ff, y1_in, y2_ff, y2_in;
   ang_type a_ff, a_in, d_ff, d_in, ph_ff, ph_in;
   wide_type dr_ff, dr_in, db_ff, db_in, distr_ff, distr_in, distb_ff, distb_in;
   wide_type dx_ff, dx_in, dy_ff, dy_in;
   cor_type x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic flip_ff, flip_in;
   cor_type sind_ff, sind_in, sina_ff, sina_in, cosa_ff, cosa_in, sinc_ff, sinc_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [COR_W-1:0] q_ff, q_in;
   logic [PROD_W-1:0] ua_ff, ua_in, pacc_ff, pacc_in;
   logic [COR_W-1:0] ub_ff, ub_in;
   logic pneg_ff, pneg_in;
   logic [POS_W-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic [POS_W-1:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic rv_ff, rv_in;
   logic [IPC_W-1:0] ipc_ff, ipc_in;
   logic signed [OFF_W-1:0] roff_ff, roff_in, boff_ff, boff_in;

   always_comb begin
      logic signed [YAW_W:0] ysum;
      logic [YAW_W:0]        ymag;
      logic [35:0]           yprod;
      ang_type               am, t;
      logic [CNT_W-1:0]      dcr, dcb;
      logic signed [CNT_W+IPC_W:0] pr, pb;
      cor_type               c, xs, ys, at;
      logic [REM_W-1:0]      rsh;
      wide_type              opa, res;
      cor_type               opb;
      logic [WIDE_W-1:0]     amag;
      logic [PROD_W-1:0]     rr;

      rc_in = rc_ff; bc_in = bc_ff; prc_in = prc_ff; pbc_in = pbc_ff;
      y1_in = y1_ff; y2_in = y2_ff; a_in = a_ff; d_in = d_ff; ph_in = ph_ff;
      dr_in = dr_ff; db_in = db_ff; distr_in = distr_ff; distb_in = distb_ff;
      dx_in = dx_ff; dy_in = dy_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff;
      flip_in = flip_ff; sind_in = sind_ff; sina_in = sina_ff; cosa_in = cosa_ff;
      sinc_in = sinc_ff; num_in = num_ff; rem_in = rem_ff; q_in = q_ff;
      ua_in = ua_ff; ub_in = ub_ff; pacc_in = pacc_ff; pneg_in = pneg_ff;
      accx_in = accx_ff; accy_in = accy_ff; posx_in = posx_ff; posy_in = posy_ff;
      head_in = head_ff; rv_in = rv_ff & rsp_stall;
      ipc_in = ipc_ff; roff_in = roff_ff; boff_in = boff_ff;

      ysum = $signed({y1_ff[YAW_W-1], y1_ff}) + $signed({y2_ff[YAW_W-1], y2_ff});
      ymag = ysum[YAW_W] ? (YAW_W+1)'(-ysum) : ysum;
      yprod = 36'(ymag) * YAW_K;
      am = ANG_W'((yprod + (36'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
      dcr = rc_ff - prc_ff;
      dcb = bc_ff - pbc_ff;
      pr = $signed(dcr) * $signed({1'b0, ipc_ff});
      pb = $signed(dcb) * $signed({1'b0, ipc_ff});
      t = a_ff;
      c = '0;
      xs = x_ff >>> cmd.step;
      ys = y_ff >>> cmd.step;
      at = atan_q(cmd.step[4:0]);
      rsh = {rem_ff[REM_W-2:0], num_ff[DIV_W-1]};

      case (cmd.slot)
         SLOT_R_SINC: begin opa = dr_ff;                 opb = sinc_ff; end
         SLOT_R_OFF:  begin opa = WIDE_W'(roff_ff);      opb = sind_ff; end
         SLOT_B_SINC: begin opa = db_ff;                 opb = sinc_ff; end
         SLOT_B_OFF:  begin opa = WIDE_W'(boff_ff);      opb = sind_ff; end
         SLOT_X_R:    begin opa = distr_ff;              opb = sina_ff; end
         SLOT_X_B:    begin opa = distb_ff;              opb = cosa_ff; end
         SLOT_Y_R:    begin opa = distr_ff;              opb = cosa_ff; end
         default:     begin opa = distb_ff;              opb = sina_ff; end
      endcase
      amag = opa[WIDE_W-1] ? WIDE_W'(-opa) : opa;
      rr = (pacc_ff + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      res = pneg_ff ? -wide_type'(rr[WIDE_W-1:0]) : wide_type'(rr[WIDE_W-1:0]);

      unique case (cmd.op)
         OP_LOAD: begin
            rc_in = req_right_count; bc_in = req_back_count;
            y1_in = req_first_yaw;   y2_in = req_second_yaw;
         end
         OP_YAW: a_in = ysum[YAW_W] ? -am : am;
         OP_ANGLE: begin
            if (t >= TWO_PI_A) t = t - TWO_PI_A;
            if (t < 0) t = t + TWO_PI_A;
            a_in = t;
            dr_in = WIDE_W'(pr);
            db_in = WIDE_W'(pb);
         end
         OP_DIFF: begin
            t = a_ff - ph_ff;
            if (t > PI_A) t = t - TWO_PI_A;
            else if (t <= -PI_A) t = t + TWO_PI_A;
            d_in = t;
            ph_in = a_ff; prc_in = rc_ff; pbc_in = bc_ff;
            distr_in = dr_ff; distb_in = db_ff;
         end
         OP_CD_INIT, OP_CA_INIT: begin
            c = (cmd.op == OP_CD_INIT) ? COR_W'(d_ff) : COR_W'(a_ff);
            if (c > PI_C) c = c - TWO_PI_C;
            if (c <= -PI_C) c = c + TWO_PI_C;
            flip_in = 1'b0;
            if (c > HALF_PI_C) begin
               c = c - PI_C; flip_in = 1'b1;
            end else if (c < -HALF_PI_C) begin
               c = c + PI_C; flip_in = 1'b1;
            end
            x_in = GAIN_C; y_in = '0; z_in = c;
         end
         OP_COR_ITER: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
            end
         end
         OP_CD_DONE: sind_in = flip_ff ? -y_ff : y_ff;
         OP_CA_DONE: begin
            sina_in = flip_ff ? -y_ff : y_ff;
            cosa_in = flip_ff ? -x_ff : x_ff;
         end
         OP_DIV_INIT: begin
            num_in = DIV_W'(sind_ff[COR_W-1] ? COR_W'(-sind_ff) : sind_ff) << FRAC_BITS;
            rem_in = '0;
            q_in = '0;
         end
         OP_DIV_ITER: begin
            num_in = num_ff << 1;
            if (rsh >= REM_W'(d_ff[ANG_W-1] ? ANG_W'(-d_ff) : d_ff)) begin
               rem_in = rsh - REM_W'(d_ff[ANG_W-1] ? ANG_W'(-d_ff) : d_ff);
               q_in = {q_ff[COR_W-2:0], 1'b1};
            end else begin
               rem_in = rsh;
               q_in = {q_ff[COR_W-2:0], 1'b0};
            end
         end
         OP_DIV_DONE:
            sinc_in = (sind_ff[COR_W-1] != d_ff[ANG_W-1]) ? -cor_type'(q_ff) : cor_type'(q_ff);
         OP_MUL_INIT: begin
            ua_in = PROD_W'(amag);
            ub_in = opb[COR_W-1] ? COR_W'(-opb) : opb;
            pneg_in = opa[WIDE_W-1] != opb[COR_W-1];
            pacc_in = '0;
         end
         OP_MUL_ITER: begin
            if (ub_ff[0]) pacc_in = pacc_ff + ua_ff;
            ua_in = ua_ff << 1;
            ub_in = ub_ff >> 1;
         end
         OP_MUL_DONE: begin
            case (cmd.slot)
               SLOT_R_SINC: distr_in = res;
               SLOT_R_OFF:  distr_in = distr_ff + res;
               SLOT_B_SINC: distb_in = res;
               SLOT_B_OFF:  distb_in = distb_ff + res;
               SLOT_X_R:    dx_in = res;
               SLOT_X_B:    dx_in = dx_ff + res;
               SLOT_Y_R:    dy_in = res;
               default:     dy_in = dy_ff - res;
            endcase
         end
         OP_ACCUM: begin
            accx_in = accx_ff + dx_ff[POS_W-1:0];
            accy_in = accy_ff + dy_ff[POS_W-1:0];
            posx_in = accx_ff + dx_ff[POS_W-1:0];
            posy_in = accy_ff + dy_ff[POS_W-1:0];
            head_in = a_ff[HEAD_W-1:0];
            rv_in = 1'b1;
         end
         default: ;
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            REG_INCH_PER_COUNT: ipc_in = csr_data[IPC_W-1:0];
            REG_RIGHT_OFFSET:   roff_in = csr_data;
            REG_BACK_OFFSET:    boff_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prc_ff <= '0; pbc_ff <= '0; ph_ff <= '0;
         accx_ff <= '0; accy_ff <= '0; rv_ff <= 1'b0;
         ipc_ff <= IPC_RESET; roff_ff <= '0; boff_ff <= '0;
      end else begin
         prc_ff <= prc_in; pbc_ff <= pbc_in; ph_ff <= ph_in;
         accx_ff <= accx_in; accy_ff <= accy_in; rv_ff <= rv_in;
         ipc_ff <= ipc_in; roff_ff <= roff_in; boff_ff <= boff_in;
      end
   end

   always_ff @(posedge clock) begin
      rc_ff <= rc_in; bc_ff <= bc_in; y1_ff <= y1_in; y2_ff <= y2_in;
      a_ff <= a_in; d_ff <= d_in; dr_ff <= dr_in; db_ff <= db_in;
      distr_ff <= distr_in; distb_ff <= distb_in; dx_ff <= dx_in; dy_ff <= dy_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; flip_ff <= flip_in;
      sind_ff <= sind_in; sina_ff <= sina_in; cosa_ff <= cosa_in; sinc_ff <= sinc_in;
      num_ff <= num_in; rem_ff <= rem_in; q_ff <= q_in;
      ua_ff <= ua_in; ub_ff <= ub_in; pacc_ff <= pacc_in; pneg_ff <= pneg_in;
      posx_ff <= posx_in; posy_ff <= posy_in; head_ff <= head_in;
   end

   assign stat.d_zero   = (d_ff == '0);
   assign stat.out_free = !rv_ff || !rsp_stall;
   assign rsp_valid   = rv_ff;
   assign rsp_pos_x   = posx_ff;
   assign rsp_pos_y   = posy_ff;
   assign rsp_heading = head_ff;

   `ASSERT_IMPLY(a_div_nonzero, clock, reset, cmd.op == OP_DIV_ITER, d_ff != '0)
   `ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rv_ff), $past(cmd.op) == OP_ACCUM)
   `ASSERT_IMPLY(a_head_range, clock, reset, cmd.op == OP_ACCUM, a_ff >= 0 && a_ff < TWO_PI_A)

endmodule

/* hdl/tracking_wheel_odometry.sv */
// Top level of tracking-wheel odometry: one sample word in, one position word out.
// A sample with a heading change also runs the CORDIC and the divider; req_stall holds off new samples until done.
// Cost is set by the bit-serial multiplier (up to 8 products), CORDIC and divider.
// The next sample word is taken while the last result word still waits for its sink.
// Synchronous active-high reset clears position, history and control; config to defaults.
`timescale 1ns / 1ps
module tracking_wheel_odometry import two_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CNT_W-1:0]  req_right_count,
   input  logic signed [CNT_W-1:0]  req_back_count,
   input  logic signed [YAW_W-1:0]  req_first_yaw,
   input  logic signed [YAW_W-1:0]  req_second_yaw,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [POS_W-1:0]  rsp_pos_x,
   output logic signed [POS_W-1:0]  rsp_pos_y,
   output logic [HEAD_W-1:0]        rsp_heading,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [OFF_W-1:0]         csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   two_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   two_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_right_count (req_right_count),
      .req_back_count  (req_back_count),
      .req_first_yaw   (req_first_yaw),
      .req_second_yaw  (req_second_yaw),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_heading     (rsp_heading)
   );

endmodule
